@@ design/sddmm_pkg.sv @@
// Package for the sampled dense-dense matrix multiply engine.
// Holds default sizes, operation codes and the field widths of the stream words.
// No dependencies.
`default_nettype none

package sddmm_pkg;

    // Default matrix sizes
    localparam int B_ROWS_DEF    = 64;
    localparam int C_ROWS_DEF    = 64;
    localparam int INNER_MAX_DEF = 64;

    // Field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 32;
    localparam int DOT_W   = 38;
    localparam int LEN_W   = 7;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    // Register reset value and map
    localparam logic [LEN_W-1:0] INNER_LEN_RST = 7'd64;
    localparam int               PADDR_W       = 3;
    localparam logic             REG_INNER_LEN = 1'b0;

    // Operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_WR_B  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_C  = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

endpackage

`default_nettype wire

@@ design/sampled_dense_dense_matmul_top.sv @@
// A sample word runs len multiply-accumulate steps (registered read, multiply, add), then the
// result is loaded into the output register; len = min(inner_len, INNER_MAX), or 0 when a row index is out of range.
// The single shared multiply-accumulate takes no new sample until the last result is loaded into
// the output register, which waits while the output stalls; load words are taken one per cycle while idle.
// Reset clears control state and inner_len (64); the B and C memories are not cleared.
// Top level of the sampled dense-dense matrix multiply engine; depends on sddmm_pkg.
`default_nettype none

module sampled_dense_dense_matmul_top #(
    parameter int B_ROWS    = sddmm_pkg::B_ROWS_DEF,
    parameter int C_ROWS    = sddmm_pkg::C_ROWS_DEF,
    parameter int INNER_MAX = sddmm_pkg::INNER_MAX_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Input stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: row_sel[5:0], col_sel[11:6], elem_value[27:12], zero[31:28]
    input  wire  [sddmm_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // tuser: op[1:0]
    input  wire  [sddmm_pkg::OP_W-1:0]        s_axis_tuser,
    // Output stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // tdata: out_row[5:0], out_col[11:6], dot_value[49:12], zero[55:50]
    output logic [sddmm_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // Configuration port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [sddmm_pkg::PADDR_W-1:0]     paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int B_DEPTH = B_ROWS * INNER_MAX;
    localparam int C_DEPTH = C_ROWS * INNER_MAX;
    localparam int BA_W    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int CA_W    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
    localparam int KW      = $clog2(INNER_MAX + 1);

    localparam int IDX_W  = sddmm_pkg::IDX_W;
    localparam int ELEM_W = sddmm_pkg::ELEM_W;
    localparam int PROD_W = sddmm_pkg::PROD_W;
    localparam int DOT_W  = sddmm_pkg::DOT_W;
    localparam int LEN_W  = sddmm_pkg::LEN_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    typedef logic signed [ELEM_W-1:0] t_elem;

    logic [1:0]              r_state, n_state;
    logic [LEN_W-1:0]        r_inner_len;
    logic [IDX_W-1:0]        r_row, r_col;
    logic [KW-1:0]           r_k, r_left;
    logic                    r_rd_vld, r_prod_vld;
    t_elem                   r_b_q, r_c_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DOT_W-1:0] r_acc;
    logic                    r_out_vld;
    logic [sddmm_pkg::M_DATA_W-1:0] r_out_data;

    t_elem                   b_mem [B_DEPTH];
    t_elem                   c_mem [C_DEPTH];

    logic                    w_in_acc, w_out_acc;
    logic [IDX_W-1:0]        w_row, w_col;
    t_elem                   w_elem;
    logic [KW-1:0]           w_len;
    logic                    w_issue, w_load_out;
    logic                    w_cfg_wr;
    logic [BA_W-1:0]         w_b_waddr, w_b_raddr;
    logic [CA_W-1:0]         w_c_waddr, w_c_raddr;

    // Unpack the input word
    assign w_row  = s_axis_tdata[IDX_W-1:0];
    assign w_col  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_elem = s_axis_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == sddmm_pkg::REG_INNER_LEN)
                      ? {{(32-LEN_W){1'b0}}, r_inner_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_len <= sddmm_pkg::INNER_LEN_RST;
        end else if (w_cfg_wr && paddr[2] == sddmm_pkg::REG_INNER_LEN) begin
            r_inner_len <= pwdata[LEN_W-1:0];
        end
    end

    // Clamp the dot product length; out-of-range rows give the empty sum
    always_comb begin
        if (32'(w_row) >= B_ROWS || 32'(w_col) >= C_ROWS) begin
            w_len = '0;
        end else if (32'(r_inner_len) > INNER_MAX) begin
            w_len = KW'(INNER_MAX);
        end else begin
            w_len = KW'(r_inner_len);
        end
    end

    // Memory addresses, row-major
    assign w_b_waddr = BA_W'(32'(w_row) * INNER_MAX + 32'(w_col));
    assign w_c_waddr = CA_W'(32'(w_row) * INNER_MAX + 32'(w_col));
    assign w_b_raddr = BA_W'(32'(r_row) * INNER_MAX + 32'(r_k));
    assign w_c_raddr = CA_W'(32'(r_col) * INNER_MAX + 32'(r_k));

    // Write loads into the element memories
    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == sddmm_pkg::OP_WR_B
                && 32'(w_row) < B_ROWS && 32'(w_col) < INNER_MAX) begin
            b_mem[w_b_waddr] <= w_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == sddmm_pkg::OP_WR_C
                && 32'(w_row) < C_ROWS && 32'(w_col) < INNER_MAX) begin
            c_mem[w_c_waddr] <= w_elem;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        r_b_q <= b_mem[w_b_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_c_q <= c_mem[w_c_raddr];
    end

    // Sequencer control
    assign w_issue    = (r_state == ST_RUN) && (r_left != '0);
    assign w_load_out = (r_state == ST_FINISH) && (!r_out_vld || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && s_axis_tuser == sddmm_pkg::OP_SAMPLE) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_left == '0 && !r_rd_vld && !r_prod_vld) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_k        <= '0;
            r_left     <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= w_issue;
            r_prod_vld <= r_rd_vld;
            // Start a sample: reset the index walk
            if (r_state == ST_IDLE && w_in_acc && s_axis_tuser == sddmm_pkg::OP_SAMPLE) begin
                r_k    <= '0;
                r_left <= w_len;
            end else if (w_issue) begin
                r_k    <= r_k + 1'b1;
                r_left <= r_left - 1'b1;
            end
        end
    end

    // Hold the sampled indices
    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == sddmm_pkg::OP_SAMPLE) begin
            r_row <= w_row;
            r_col <= w_col;
        end
    end

    // Shared multiply-accumulate: multiply, then add
    always_ff @(posedge i_clk) begin
        r_prod <= r_b_q * r_c_q;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == sddmm_pkg::OP_SAMPLE) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + DOT_W'(r_prod);
        end
    end

    // Output register: load the finished word, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (w_out_acc) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {{(sddmm_pkg::M_DATA_W-DOT_W-2*IDX_W){1'b0}}, r_acc, r_col, r_row};
        end
    end

`ifndef NO_ASSERTIONS
    // Busy sequencer never takes input
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while a sample is in progress");

    // Idle means the multiply-accumulate pipeline is empty
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_left == '0 && !r_rd_vld && !r_prod_vld))
        else $error("pipeline not drained in idle");

    // An accepted sample starts the walk
    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tuser == sddmm_pkg::OP_SAMPLE) |=> (r_state == ST_RUN))
        else $error("accepted sample did not start");
`endif

endmodule

`default_nettype wire
